FILE: rtl/core/ghdt_pkg.sv
// ----------------------------------------------------------------------------
// ghdt_pkg
// Shared types and constants for the gridpoint haplotype dedup table.
// ----------------------------------------------------------------------------
package ghdt_pkg;
    localparam int GRIDPOINTS = 1024;
    localparam int MAX_LOCI   = 32;
    localparam int MAX_UNIQUE = 16;
    localparam int GP_W    = 10;
    localparam int KEY_W   = 32;
    localparam int UIDX_W  = $clog2(MAX_UNIQUE);
    localparam int CNT_W   = $clog2(MAX_UNIQUE + 1);
    localparam int POS_W   = 6;
    localparam int ADDR_W  = GP_W + UIDX_W;
    localparam int QDEPTH  = 2;

    // classify request passed from front to back
    typedef struct packed {
        logic [GP_W-1:0]  gp;
        logic [KEY_W-1:0] key;
        logic             first;
    } t_req;

    typedef struct packed {
        logic [GP_W-1:0]   gp;
        logic [UIDX_W-1:0] idx;
        logic              is_new;
        logic              ovf;
        logic [KEY_W-1:0]  key;
    } t_res;
endpackage

FILE: rtl/core/ghdt_front.sv
// ----------------------------------------------------------------------------
// ghdt_front
// Packs allele bits per gridpoint and emits a request at each last locus.
// ----------------------------------------------------------------------------
module ghdt_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ghdt_pkg::GP_W-1:0]    i_gridpoint,
    input  logic                         i_allele,
    input  logic                         i_last,
    input  logic                         i_first,
    output logic                         o_req_valid,
    input  logic                         i_req_ready,
    output ghdt_pkg::t_req               o_req
);
    logic [ghdt_pkg::KEY_W-1:0] r_key, n_key;
    logic [ghdt_pkg::POS_W-1:0] r_pos;
    logic in_range;

    // only a last locus in range needs queue space
    assign in_range    = ({6'd0, i_gridpoint} < 16'(ghdt_pkg::GRIDPOINTS));
    assign o_ready     = !(i_last && in_range) || i_req_ready;
    assign o_req_valid = i_valid && i_last && in_range;

    always_comb begin
        n_key = r_key;
        if (i_allele && r_pos < 6'(ghdt_pkg::MAX_LOCI) && r_pos < 6'd32)
            n_key[r_pos[4:0]] = 1'b1;
    end

    assign o_req.gp    = i_gridpoint;
    assign o_req.key   = n_key;
    assign o_req.first = i_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_pos <= '0;
        end else if (i_valid && o_ready) begin
            if (i_last) begin
                r_key <= '0;
                r_pos <= '0;
            end else begin
                r_key <= n_key;
                if (r_pos < 6'(ghdt_pkg::MAX_LOCI)) r_pos <= r_pos + 6'd1;
            end
        end
    end
endmodule

FILE: rtl/core/ghdt_queue.sv
// ----------------------------------------------------------------------------
// ghdt_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module ghdt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ghdt_pkg::t_req i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ghdt_pkg::t_req o_data
);
    ghdt_pkg::t_req r_mem [ghdt_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'(ghdt_pkg::QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: rtl/core/ghdt_back.sv
// ----------------------------------------------------------------------------
// ghdt_back
// Searches a gridpoint's key table one entry at a time and appends on a miss.
// ----------------------------------------------------------------------------
module ghdt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ghdt_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output ghdt_pkg::t_res o_res
);
    localparam int UW = ghdt_pkg::UIDX_W;
    localparam int CW = ghdt_pkg::CNT_W;

    typedef enum logic [2:0] {S_IDLE, S_CNT, S_RD, S_CMP, S_OUT} t_state;
    t_state r_state;

    logic [ghdt_pkg::KEY_W-1:0] r_keys [ghdt_pkg::GRIDPOINTS*ghdt_pkg::MAX_UNIQUE];
    logic [CW-1:0]              r_cnts [ghdt_pkg::GRIDPOINTS];

    ghdt_pkg::t_req r_req;
    logic [CW-1:0] r_count, r_cntrd;
    logic [CW-1:0] r_i;
    logic [ghdt_pkg::KEY_W-1:0] r_rd;
    logic r_kwe, r_cwe;
    logic [ghdt_pkg::ADDR_W-1:0] r_kwa, n_ra;
    logic [ghdt_pkg::KEY_W-1:0] r_kwd;
    logic [ghdt_pkg::GP_W-1:0] r_cwa;
    logic [CW-1:0] r_cwd;
    logic r_out_v;
    ghdt_pkg::t_res r_res;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_v;
    assign o_res   = r_res;
    assign n_ra    = {r_req.gp, r_i[UW-1:0]};

    // memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (r_kwe) r_keys[r_kwa] <= r_kwd;
        if (r_cwe) r_cnts[r_cwa] <= r_cwd;
        r_rd    <= r_keys[n_ra];
        r_cntrd <= r_cnts[r_req.gp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_kwe <= 1'b0;
            r_cwe <= 1'b0;
        end else begin
            r_kwe <= 1'b0;
            r_cwe <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_req   <= i_req;
                    r_i     <= '0;
                    r_state <= i_req.first ? S_OUT : S_CNT;
                end
                S_CNT: r_state <= S_RD; // count read in flight
                S_RD: begin
                    r_count <= (r_cntrd > CW'(ghdt_pkg::MAX_UNIQUE))
                               ? CW'(ghdt_pkg::MAX_UNIQUE) : r_cntrd;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // r_rd holds entry r_i
                    if (r_i < r_count && r_rd == r_req.key) begin
                        r_res <= '{r_req.gp, r_i[UW-1:0], 1'b0, 1'b0, r_req.key};
                        r_out_v <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_i >= r_count) begin
                        if (r_count < CW'(ghdt_pkg::MAX_UNIQUE)) begin
                            r_kwe <= 1'b1; r_kwa <= n_ra; r_kwd <= r_req.key;
                            r_cwe <= 1'b1; r_cwa <= r_req.gp; r_cwd <= r_count + CW'(1);
                            r_res <= '{r_req.gp, r_count[UW-1:0], 1'b1, 1'b0, r_req.key};
                        end else
                            r_res <= '{r_req.gp, '0, 1'b0, 1'b1, r_req.key};
                        r_out_v <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_out_v) begin
                        // first genome: reset table to this key
                        r_kwe <= 1'b1; r_kwa <= {r_req.gp, {UW{1'b0}}}; r_kwd <= r_req.key;
                        r_cwe <= 1'b1; r_cwa <= r_req.gp; r_cwd <= CW'(1);
                        r_res <= '{r_req.gp, '0, 1'b1, 1'b0, r_req.key};
                        r_out_v <= 1'b1;
                    end else if (i_ready) begin
                        r_out_v <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/grid_haplotype_dedup_table.sv
// ----------------------------------------------------------------------------
// grid_haplotype_dedup_table
// Per-gridpoint dedup table of packed allele haplotype keys.
// ----------------------------------------------------------------------------
// Usage: one locus per input request (gridpoint, allele, last mark, first
// genome flag). Non-last loci are taken every cycle by the front, which packs
// allele bits into a key. A last locus with an in-range gridpoint pushes a
// classify request into a two-entry queue; the back reads the gridpoint's
// count, then compares stored keys one entry at a time (registered memory
// read plus compare), matching on the first hit or appending on a miss,
// or flagging overflow when the table is full. One result request leaves per
// classified gridpoint. The back takes a new classify request only once
// the previous result is taken, and the key memory scan sets throughput.
// A first genome skips the scan and resets the table to its key.
// Reset clears the accumulator, queue and sequencer; the tables are
// undefined until written by a first-genome request. When the receiver
// stalls the result is held and the back stops; the queue then fills and
// last loci are refused, while other loci still stream in.
// ----------------------------------------------------------------------------
module grid_haplotype_dedup_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [9:0]                       i_gridpoint,
    input  logic                             i_allele,
    input  logic                             i_last_in_gridpoint,
    input  logic                             i_first_genome,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [9:0]                       o_grid_index,
    output logic [ghdt_pkg::UIDX_W-1:0]      o_hap_index,
    output logic                             o_is_new,
    output logic                             o_overflow,
    output logic [31:0]                      o_pattern_key
);
    ghdt_pkg::t_req fq_req, qb_req;
    ghdt_pkg::t_res res;
    logic fq_v, fq_r, qb_v, qb_r;

    ghdt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_gridpoint, .i_allele, .i_last(i_last_in_gridpoint), .i_first(i_first_genome),
        .o_req_valid(fq_v), .i_req_ready(fq_r), .o_req(fq_req)
    );

    ghdt_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(fq_v), .o_ready(fq_r), .i_data(fq_req),
        .o_valid(qb_v), .i_ready(qb_r), .o_data(qb_req)
    );

    ghdt_back u_back (
        .i_clk, .i_rst_n, .i_valid(qb_v), .o_ready(qb_r), .i_req(qb_req),
        .o_valid, .i_ready, .o_res(res)
    );

    assign o_grid_index  = res.gp;
    assign o_hap_index   = res.idx;
    assign o_is_new      = res.is_new;
    assign o_overflow    = res.ovf;
    assign o_pattern_key = res.key;
endmodule

FILE: rtl/core/ghdt_checker.sv
// ----------------------------------------------------------------------------
// ghdt_checker
// Port-level checks for the dedup table.
// ----------------------------------------------------------------------------
module ghdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_is_new,
    input logic        o_overflow,
    input logic [3:0]  o_hap_index,
    input logic [31:0] o_pattern_key
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pattern_key))
        else $error("result dropped under stall");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_new && o_overflow))
        else $error("new and overflow together");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_hap_index == 4'd0)
        else $error("overflow index nonzero");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind grid_haplotype_dedup_table ghdt_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_is_new, .o_overflow,
    .o_hap_index, .o_pattern_key
);
